// ----- sv/stepper_ramp_step_controller_macros.svh -----
// Assertion macros for the stepper ramp step controller checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef STEPPER_RAMP_STEP_CONTROLLER_MACROS_SVH
`define STEPPER_RAMP_STEP_CONTROLLER_MACROS_SVH

// Check on every clock edge, suspended while reset is asserted.
`define SRSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that keeps running through reset.
`define SRSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/srsc_pkg.sv -----
// Shared types, constants and the coil table of the stepper ramp controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package srsc_pkg;

    localparam int NUM_MOTORS     = 3;
    localparam int DONE_TOLERANCE = 5;

    localparam int CNT_W    = 16;
    localparam int SEL_W    = 2;
    localparam int ENC_W    = 12;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int STEP_W   = 32;
    localparam int COIL_W   = 4;
    localparam int EN_W     = 3;
    localparam int PHASE_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 2 * CFG_W;
    localparam int DIST_W   = POS_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS = CFG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SPAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY   = 2'd2;

    localparam int RESET_SPAN  = 100;
    localparam int RESET_START = 5000;
    localparam int RESET_MIN   = 1000;
    localparam int RESET_SLOPE = (RESET_START > RESET_MIN) ?
                                 (RESET_START - RESET_MIN) / RESET_SPAN : 0;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_UPDATE = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_COMMIT
    } back_state_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [CNT_W-1:0]        count;
        logic [POS_W-1:0]        delta;
        logic                    fwd;
        logic [EN_W-1:0]         enable;
        logic [ENC_W-1:0]        enc;
        logic [TIME_W-1:0]       now;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] span;
        logic [CFG_W-1:0] start;
        logic [CFG_W-1:0] min;
        logic [CFG_W-1:0] slope;
    } cfg_t;

    // Two-phase-on full-step sequence
    function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0:    c = 4'h5;
            2'd1:    c = 4'h6;
            2'd2:    c = 4'hA;
            2'd3:    c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/srsc_cfg.sv -----
// Ramp configuration registers and the shift-subtract divider for the slope.
// Depends on srsc_pkg.
`default_nettype none

module srsc_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [srsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srsc_pkg::CFG_W-1:0]     cfg_data,
    output srsc_pkg::cfg_t                      cfg,
    output logic                                busy
);
    import srsc_pkg::*;

    logic [CFG_W-1:0]     span_reg, start_reg, min_reg, slope_reg;
    logic [CFG_W-1:0]     span_next, start_next, min_next;
    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CFG_W-1:0]     quo_reg, rem_reg, den_reg;

    logic                 wr, known;
    logic [CFG_W-1:0]     num, den;
    logic [CFG_W:0]       rem_sh;
    logic                 ge;
    logic [CFG_W-1:0]     rem_new, quo_new;

    assign cfg_ready = !busy_reg;
    assign busy      = busy_reg;
    assign wr        = cfg_valid && cfg_ready;
    assign known     = (cfg_index == CFG_RAMP_SPAN) || (cfg_index == CFG_START_DELAY)
                       || (cfg_index == CFG_MIN_DELAY);

    always_comb
    begin
        span_next  = span_reg;
        start_next = start_reg;
        min_next   = min_reg;
        if (wr)
        begin
            case (cfg_index)
                CFG_RAMP_SPAN:   span_next  = cfg_data;
                CFG_START_DELAY: start_next = cfg_data;
                CFG_MIN_DELAY:   min_next   = cfg_data;
                default:         ;
            endcase
        end
        num = (start_next > min_next) ? (start_next - min_next) : '0;
        den = (span_next == '0) ? CFG_W'(1) : span_next;
    end

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[CFG_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? CFG_W'(rem_sh - {1'b0, den_reg}) : rem_sh[CFG_W-1:0];
        quo_new = {quo_reg[CFG_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg  <= CFG_W'(RESET_SPAN);
            start_reg <= CFG_W'(RESET_START);
            min_reg   <= CFG_W'(RESET_MIN);
            slope_reg <= CFG_W'(RESET_SLOPE);
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            span_reg  <= span_next;
            start_reg <= start_next;
            min_reg   <= min_next;
            if (wr && known)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg  <= 1'b0;
                    slope_reg <= quo_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && known)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_new;
            rem_reg <= rem_new;
        end
    end

    assign cfg.span  = span_reg;
    assign cfg.start = start_reg;
    assign cfg.min   = min_reg;
    assign cfg.slope = slope_reg;

endmodule

`default_nettype wire

// ----- sv/srsc_front.sv -----
// Input side: accepts beats, decodes start/update and pre-computes the
// target delta and motor enable. Depends on srsc_pkg.
`default_nettype none

module srsc_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [srsc_pkg::CNT_W-1:0]  move_count,
    input  wire logic                        move_forward,
    input  wire logic [srsc_pkg::SEL_W-1:0]  motor_select,
    input  wire logic [srsc_pkg::ENC_W-1:0]  encoder_position,
    input  wire logic [srsc_pkg::TIME_W-1:0] now_us,
    input  wire logic                        cfg_busy,
    input  wire logic                        q_full,
    output logic                             push,
    output srsc_pkg::item_t                  item
);
    import srsc_pkg::*;

    logic [POS_W-1:0] count_ext;

    assign in_stall  = cfg_busy || q_full;
    assign push      = in_valid && !in_stall;
    assign count_ext = {{(POS_W-CNT_W){1'b0}}, move_count};

    always_comb
    begin
        item.kind   = operation ? KIND_UPDATE : KIND_START;
        item.count  = move_count;
        item.delta  = move_forward ? count_ext : (POS_W'(0) - count_ext);
        item.fwd    = move_forward;
        item.enable = (int'(motor_select) < NUM_MOTORS) ? EN_W'(1 << motor_select) : '0;
        item.enc    = encoder_position;
        item.now    = now_us;
    end

endmodule

`default_nettype wire

// ----- sv/srsc_queue.sv -----
// Short FIFO of decoded items between the front and the back.
// Depends on srsc_pkg.
`default_nettype none

module srsc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire srsc_pkg::item_t push_item,
    input  wire logic            pop,
    output srsc_pkg::item_t      head,
    output logic                 full,
    output logic                 empty
);
    import srsc_pkg::*;

    item_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- sv/srsc_back.sv -----
// Execution side: distance check, ramp delay (one registered multiply),
// step decision, motion state and the result register. Depends on srsc_pkg.
`default_nettype none

module srsc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire srsc_pkg::cfg_t              cfg,
    input  wire srsc_pkg::item_t             head,
    input  wire logic                        q_empty,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [srsc_pkg::COIL_W-1:0]      coil_pattern,
    output logic [srsc_pkg::EN_W-1:0]        motor_enables,
    output logic                             move_done,
    output logic                             step_taken
);
    import srsc_pkg::*;

    back_state_t state_reg, state_next;
    logic        load, calc, commit;
    logic        out_free;

    // working item and calc-stage results
    item_t             item_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              use_min_reg;
    logic              near_reg;

    // motion state
    logic [PHASE_W-1:0] phase_reg;
    logic [POS_W-1:0]   target_reg;
    logic               dir_reg;
    logic [TIME_W-1:0]  stamp_reg;
    logic [STEP_W-1:0]  done_cnt_reg, left_cnt_reg;
    logic [EN_W-1:0]    enables_reg;
    logic [COIL_W-1:0]  coil_reg;
    logic               out_valid_reg, done_out_reg, step_out_reg;

    logic signed [DIST_W-1:0] pos_err;
    logic                     near;
    logic                     ramp_up, ramp_down;
    logic [CFG_W-1:0]         mul_b;
    logic [TIME_W-1:0]        delay, elapsed;
    logic                     take;
    logic [PHASE_W-1:0]       phase_step;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        calc       = 1'b0;
        commit     = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    load       = 1'b1;
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                calc       = 1'b1;
                state_next = BK_COMMIT;
            end
            BK_COMMIT:
            begin
                if (out_free)
                begin
                    commit = 1'b1;
                    if (!q_empty)
                    begin
                        pop        = 1'b1;
                        load       = 1'b1;
                        state_next = BK_CALC;
                    end
                    else
                        state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // calc stage: distance to target and ramp operand
    always_comb
    begin
        pos_err = $signed({{(DIST_W-ENC_W){1'b0}}, item_reg.enc})
                  - $signed({{(DIST_W-POS_W){target_reg[POS_W-1]}}, target_reg});
        near = (pos_err < DIST_W'(DONE_TOLERANCE)) && (pos_err > -DIST_W'(DONE_TOLERANCE));
        ramp_up   = done_cnt_reg < {{(STEP_W-CFG_W){1'b0}}, cfg.span};
        ramp_down = left_cnt_reg < {{(STEP_W-CFG_W){1'b0}}, cfg.span};
        // in either ramp branch the count is below the span, so it fits CFG_W
        mul_b = ramp_up ? done_cnt_reg[CFG_W-1:0] : left_cnt_reg[CFG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= head;
        if (calc)
        begin
            prod_reg    <= PROD_W'(cfg.slope) * PROD_W'(mul_b);
            use_min_reg <= !ramp_up && !ramp_down;
            near_reg    <= near;
        end
    end

    // commit stage: step decision
    always_comb
    begin
        delay = use_min_reg ? {{(TIME_W-CFG_W){1'b0}}, cfg.min}
                            : ({{(TIME_W-CFG_W){1'b0}}, cfg.start} - prod_reg);
        elapsed    = item_reg.now - stamp_reg;
        take       = (item_reg.kind == KIND_UPDATE) && !near_reg && (elapsed > delay);
        phase_step = dir_reg ? (phase_reg + 1'b1) : (phase_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            target_reg    <= '0;
            dir_reg       <= 1'b0;
            stamp_reg     <= '0;
            done_cnt_reg  <= '0;
            left_cnt_reg  <= '0;
            enables_reg   <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
            done_out_reg  <= 1'b0;
            step_out_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= commit || (out_valid_reg && out_stall);
            if (commit)
            begin
                done_out_reg <= (item_reg.kind == KIND_UPDATE) && near_reg;
                step_out_reg <= take;
                if (item_reg.kind == KIND_START)
                begin
                    target_reg   <= target_reg + item_reg.delta;
                    dir_reg      <= item_reg.fwd;
                    stamp_reg    <= item_reg.now;
                    done_cnt_reg <= '0;
                    left_cnt_reg <= {{(STEP_W-CNT_W){1'b0}}, item_reg.count};
                    enables_reg  <= item_reg.enable;
                end
                else if (near_reg)
                    coil_reg <= '0;
                else if (take)
                begin
                    stamp_reg <= item_reg.now;
                    if (done_cnt_reg != '1)
                        done_cnt_reg <= done_cnt_reg + 1'b1;
                    if (left_cnt_reg != '0)
                        left_cnt_reg <= left_cnt_reg - 1'b1;
                    phase_reg <= phase_step;
                    coil_reg  <= phase_coils(phase_step);
                end
            end
        end
    end

    // coil and enable state only change on commit, which waits for a free output
    assign out_valid     = out_valid_reg;
    assign coil_pattern  = coil_reg;
    assign motor_enables = enables_reg;
    assign move_done     = done_out_reg;
    assign step_taken    = step_out_reg;

endmodule

`default_nettype wire

// ----- sv/stepper_ramp_step_controller.sv -----
// An accepted input beat is queued, then loaded from the queue, ramp-multiplied and
// committed to the result register. The back end takes a new item only as it commits the
// previous one, and a stalled result holds it; a 2-entry queue absorbs bursts.
// A configuration write to a known register starts the slope division, during which
// cfg_ready and acceptance of input beats are held off.
// Reset clears all motion state, coils off, enables off; ramp regs load 100/5000/1000.
`default_nettype none

module stepper_ramp_step_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           operation,
    input  wire logic [srsc_pkg::CNT_W-1:0]     move_count,
    input  wire logic                           move_forward,
    input  wire logic [srsc_pkg::SEL_W-1:0]     motor_select,
    input  wire logic [srsc_pkg::ENC_W-1:0]     encoder_position,
    input  wire logic [srsc_pkg::TIME_W-1:0]    now_us,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [srsc_pkg::COIL_W-1:0]         coil_pattern,
    output logic [srsc_pkg::EN_W-1:0]           motor_enables,
    output logic                                move_done,
    output logic                                step_taken,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [srsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srsc_pkg::CFG_W-1:0]     cfg_data
);
    import srsc_pkg::*;

    cfg_t  cfg;
    logic  cfg_busy;
    logic  push, pop, q_full, q_empty;
    item_t push_item, head;

    srsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (cfg_busy)
    );

    srsc_front u_front (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .move_count       (move_count),
        .move_forward     (move_forward),
        .motor_select     (motor_select),
        .encoder_position (encoder_position),
        .now_us           (now_us),
        .cfg_busy         (cfg_busy),
        .q_full           (q_full),
        .push             (push),
        .item             (push_item)
    );

    srsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    srsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_pattern  (coil_pattern),
        .motor_enables (motor_enables),
        .move_done     (move_done),
        .step_taken    (step_taken)
    );

endmodule

`default_nettype wire

// ----- sv/srsc_checker.sv -----
// Port-level checks on the result channel of the stepper ramp controller,
// bound to the top level. Depends on srsc_pkg and the assertion macro header.
`default_nettype none

`include "stepper_ramp_step_controller_macros.svh"

module srsc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [srsc_pkg::COIL_W-1:0] coil_pattern,
    input wire logic [srsc_pkg::EN_W-1:0]   motor_enables,
    input wire logic                       move_done,
    input wire logic                       step_taken
);
    import srsc_pkg::*;

    logic step_coils_ok;

    // a step always lands on one of the four two-phase-on patterns
    assign step_coils_ok = (coil_pattern == phase_coils(2'd0))
                           || (coil_pattern == phase_coils(2'd1))
                           || (coil_pattern == phase_coils(2'd2))
                           || (coil_pattern == phase_coils(2'd3));

    `SRSC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
    `SRSC_ASSERT(a_done_coils_off, out_valid && move_done |-> coil_pattern == '0, "coils on")
    `SRSC_ASSERT(a_step_not_done, out_valid && step_taken |-> !move_done, "step when done")
    `SRSC_ASSERT(a_step_pattern, out_valid && step_taken |-> step_coils_ok, "bad coil pattern")
    `SRSC_ASSERT(a_enables_onehot, $onehot0(motor_enables), "more than one motor enabled")

endmodule

bind stepper_ramp_step_controller srsc_checker u_srsc_checker (.*);

`default_nettype wire

// ----- sim/tb_stepper_ramp_step_controller.sv -----
`timescale 1ns / 1ps
// Testbench for stepper_ramp_step_controller: directed and random start/update beats,
// each result checked against an in-bench model of the ramp, coil phase and target.
// Depends on srsc_pkg and the controller RTL.

module tb_stepper_ramp_step_controller;
    import srsc_pkg::*;

    typedef struct packed {
        item_kind_t          kind;
        logic [CNT_W-1:0]    count;
        logic                fwd;
        logic [SEL_W-1:0]    sel;
        logic [ENC_W-1:0]    enc;
        logic [TIME_W-1:0]   now;
    } motion_beat_t;

    typedef struct packed {
        logic [COIL_W-1:0]   coils;
        logic [EN_W-1:0]     enables;
        logic                done;
        logic                stepped;
    } drive_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = 1'b0;
    logic [CNT_W-1:0]      move_count = '0;
    logic                  move_forward = 1'b0;
    logic [SEL_W-1:0]      motor_select = '0;
    logic [ENC_W-1:0]      encoder_position = '0;
    logic [TIME_W-1:0]     now_us = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COIL_W-1:0]     coil_pattern;
    logic [EN_W-1:0]       motor_enables;
    logic                  move_done;
    logic                  step_taken;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    stepper_ramp_step_controller uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .move_count       (move_count),
        .move_forward     (move_forward),
        .motor_select     (motor_select),
        .encoder_position (encoder_position),
        .now_us           (now_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .coil_pattern     (coil_pattern),
        .motor_enables    (motor_enables),
        .move_done        (move_done),
        .step_taken       (step_taken),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 clk = ~clk;

    // Controller state as the bench sees it
    logic [CFG_W-1:0]    ramp_span, ramp_start, ramp_cruise, ramp_slope;
    logic [PHASE_W-1:0]  coil_phase;
    logic [POS_W-1:0]    goal_pos;
    logic                step_fwd;
    logic [TIME_W-1:0]   last_stamp;
    logic [STEP_W-1:0]   steps_made, steps_owed;
    logic [EN_W-1:0]     motor_en;
    logic [COIL_W-1:0]   coil_drive;

    drive_state_t coil_expect_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int errors = 0;
    int n_starts = 0, n_updates = 0, n_steps = 0, n_done = 0;
    int n_cfg_writes = 0, n_results = 0;

    function automatic logic [CFG_W-1:0] slope_for(input logic [CFG_W-1:0] span,
                                                   input logic [CFG_W-1:0] start_us,
                                                   input logic [CFG_W-1:0] cruise_us);
        logic [CFG_W-1:0] divisor;
        divisor = (span == '0) ? CFG_W'(1) : span;
        return (start_us > cruise_us) ? CFG_W'((start_us - cruise_us) / divisor) : '0;
    endfunction

    function automatic logic [COIL_W-1:0] coil_for(input logic [PHASE_W-1:0] p);
        case (p)
            2'd0:    return 4'h5;
            2'd1:    return 4'h6;
            2'd2:    return 4'hA;
            default: return 4'h9;
        endcase
    endfunction

    // Accel while few steps are done, decel while few are left, cruise in between
    function automatic logic [TIME_W-1:0] step_delay();
        if (steps_made < STEP_W'(ramp_span))
            return TIME_W'(ramp_start) - TIME_W'(ramp_slope) * steps_made;
        if (steps_owed < STEP_W'(ramp_span))
            return TIME_W'(ramp_start) - TIME_W'(ramp_slope) * steps_owed;
        return TIME_W'(ramp_cruise);
    endfunction

    function automatic logic [TIME_W-1:0] step_time(input logic [TIME_W-1:0] extra);
        return last_stamp + step_delay() + extra;
    endfunction

    function automatic drive_state_t drive_after(input motion_beat_t b);
        drive_state_t r;
        longint pos_gap;
        r = '0;
        if (b.kind == KIND_START)
        begin
            goal_pos   = b.fwd ? goal_pos + POS_W'(b.count) : goal_pos - POS_W'(b.count);
            step_fwd   = b.fwd;
            last_stamp = b.now;
            steps_made = '0;
            steps_owed = STEP_W'(b.count);
            motor_en   = (b.sel < NUM_MOTORS) ? (EN_W'(1) << b.sel) : '0;
            n_starts++;
        end
        else
        begin
            pos_gap = longint'(b.enc) - longint'($signed(goal_pos));
            if (pos_gap < 0)
                pos_gap = -pos_gap;
            if (pos_gap < DONE_TOLERANCE)
            begin
                r.done = 1'b1;
                coil_drive = '0;
                n_done++;
            end
            else if (TIME_W'(b.now - last_stamp) > step_delay())
            begin
                last_stamp = b.now;
                if (steps_made != '1)
                    steps_made++;
                if (steps_owed != '0)
                    steps_owed--;
                coil_phase = step_fwd ? coil_phase + 2'd1 : coil_phase - 2'd1;
                coil_drive = coil_for(coil_phase);
                r.stepped = 1'b1;
                n_steps++;
            end
            n_updates++;
        end
        r.coils   = coil_drive;
        r.enables = motor_en;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 50)
            $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Entered and left at a falling edge; valid stays high into the next beat unless idling
    task automatic send_beat(input motion_beat_t b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        operation        <= b.kind;
        move_count       <= b.count;
        move_forward     <= b.fwd;
        motor_select     <= b.sel;
        encoder_position <= b.enc;
        now_us           <= b.now;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        coil_expect_q.push_back(drive_after(b));
        @(negedge clk);
    endtask

    // Hold off input until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (coil_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_ramp_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RAMP_SPAN:   ramp_span = val;
            CFG_START_DELAY: ramp_start = val;
            CFG_MIN_DELAY:   ramp_cruise = val;
            default:         ;
        endcase
        ramp_slope = slope_for(ramp_span, ramp_start, ramp_cruise);
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_ramp(input logic [CFG_W-1:0] span, input logic [CFG_W-1:0] start_us,
                            input logic [CFG_W-1:0] cruise_us);
        settle();
        write_ramp_reg(CFG_RAMP_SPAN, span);
        write_ramp_reg(CFG_START_DELAY, start_us);
        write_ramp_reg(CFG_MIN_DELAY, cruise_us);
    endtask

    function automatic motion_beat_t start_beat(input logic [CNT_W-1:0] count, input logic fwd,
                                                input logic [SEL_W-1:0] sel,
                                                input logic [TIME_W-1:0] now);
        motion_beat_t b;
        b       = '0;
        b.kind  = KIND_START;
        b.count = count;
        b.fwd   = fwd;
        b.sel   = sel;
        b.enc   = ENC_W'($urandom);
        b.now   = now;
        return b;
    endfunction

    function automatic motion_beat_t update_beat(input logic [ENC_W-1:0] enc,
                                                 input logic [TIME_W-1:0] now);
        motion_beat_t b;
        b       = '0;
        b.kind  = KIND_UPDATE;
        b.count = CNT_W'($urandom);
        b.fwd   = 1'($urandom_range(1));
        b.sel   = SEL_W'($urandom_range(3));
        b.enc   = enc;
        b.now   = now;
        return b;
    endfunction

    // Mostly aims the target back into encoder range so tolerance hits happen
    function automatic motion_beat_t plan_start();
        motion_beat_t b;
        longint gap;
        longint mag;
        gap = longint'($urandom_range(4095)) - longint'($signed(goal_pos));
        mag = (gap < 0) ? -gap : gap;
        if ($urandom_range(99) < 70 && mag <= 65535)
            b = start_beat(CNT_W'(mag), gap >= 0, '0, '0);
        else if ($urandom_range(3) == 0)
            b = start_beat(CNT_W'($urandom), 1'($urandom_range(1)), '0, '0);
        else
            b = start_beat(CNT_W'($urandom_range(40)), 1'($urandom_range(1)), '0, '0);
        b.sel = ($urandom_range(9) == 0) ? SEL_W'(3) : SEL_W'($urandom_range(NUM_MOTORS - 1));
        b.now = $urandom_range(1) ? $urandom : last_stamp + $urandom_range(1000);
        return b;
    endfunction

    function automatic motion_beat_t plan_update();
        logic [ENC_W-1:0]  enc;
        logic [TIME_W-1:0] wait_us;
        logic [TIME_W-1:0] now;
        wait_us = step_delay();
        if ($urandom_range(3) == 0)
            enc = ENC_W'(goal_pos + $urandom_range(12) - 6);
        else
            enc = ENC_W'($urandom);
        case ($urandom_range(9))
            0, 1, 2: now = last_stamp + wait_us + 1 + $urandom_range(20);
            3:       now = last_stamp + wait_us;
            4:       now = last_stamp + $urandom_range(wait_us);
            5:       now = $urandom;
            6:       now = last_stamp + wait_us + $urandom;
            default: now = last_stamp + wait_us + 1;
        endcase
        return update_beat(enc, now);
    endfunction

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin : check_result
        drive_state_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (coil_expect_q.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", '0, '0);
            end
            else
            begin
                exp_r = coil_expect_q.pop_front();
                if (coil_pattern !== exp_r.coils)
                    report_mismatch("coil_pattern", 32'(coil_pattern), 32'(exp_r.coils));
                if (motor_enables !== exp_r.enables)
                    report_mismatch("motor_enables", 32'(motor_enables), 32'(exp_r.enables));
                if (move_done !== exp_r.done)
                    report_mismatch("move_done", 32'(move_done), 32'(exp_r.done));
                if (step_taken !== exp_r.stepped)
                    report_mismatch("step_taken", 32'(step_taken), 32'(exp_r.stepped));
            end
        end
    end

    task automatic check_reset_defaults();
        send_beat(update_beat('0, '0));                 // target 0, encoder 0: done
        send_beat(update_beat(12'hFFF, step_time(0)));  // elapsed equals delay: no step
        send_beat(update_beat(12'hFFF, step_time(1)));  // first step, backward
    endtask

    task automatic check_targets_and_motors();
        send_beat(start_beat(16'hFFFF, 1'b1, 2'd0, 32'hFFFF_FF00));
        send_beat(update_beat(12'hFFF, step_time(1)));  // elapsed wraps past 2^32
        send_beat(update_beat(12'hFFF, step_time(0)));
        send_beat(start_beat('0, 1'b0, 2'd3, 32'h8000_0000));  // no such motor
        send_beat(update_beat(12'hFFF, step_time(1)));  // steps left already at zero
        send_beat(start_beat(16'd63535, 1'b0, 2'd1, '0));       // target 2000
        send_beat(update_beat(12'd2005, step_time(1)));         // distance 5: still moving
        send_beat(update_beat(12'd2004, '0));                   // distance 4: done
        send_beat(update_beat(12'd1995, step_time(1)));
        send_beat(start_beat(16'd2003, 1'b0, 2'd2, $urandom));  // target -3
        send_beat(update_beat(12'd0, '0));
        send_beat(update_beat(12'd2, step_time(1)));
    endtask

    task automatic check_ramp_profile();
        set_ramp(16'd3, 16'd400, 16'd100);
        send_beat(start_beat(16'd6, 1'b1, 2'd0, 32'd100));
        repeat (7) send_beat(update_beat(12'hFFF, step_time(1)));
    endtask

    task automatic check_config_extremes();
        set_ramp(16'd0, 16'hFFFF, 16'd0);      // zero span, steepest slope
        send_beat(start_beat(16'd5, 1'b0, 2'd1, $urandom));
        send_beat(update_beat(12'hFFF, step_time(1)));
        send_beat(update_beat(12'hFFF, last_stamp));
        set_ramp(16'hFFFF, 16'd0, 16'hFFFF);   // start below cruise
        send_beat(update_beat(12'hFFF, step_time(1)));
        set_ramp(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(update_beat(12'hFFF, step_time(1)));
    endtask

    task automatic run_random_traffic(input int beats);
        int sent;
        motion_beat_t b;
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(99) < 8)
            begin
                b = update_beat(ENC_W'($urandom), $urandom);
                b.kind = item_kind_t'(1'($urandom_range(1)));
                send_beat(b);
                sent++;
            end
            else
            begin
                send_beat(plan_start());
                sent++;
                repeat ($urandom_range(30, 1))
                begin
                    if (sent < beats)
                    begin
                        send_beat(plan_update());
                        sent++;
                    end
                end
            end
            if ($urandom_range(199) == 0)
                settle();
        end
    endtask

    task automatic run_idle_mix(input int tx_pct, input int rx_pct);
        logic [CFG_W-1:0] span, start_us, cruise_us;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (3)
        begin
            span      = ($urandom_range(7) == 0) ? CFG_W'($urandom)
                                                 : CFG_W'($urandom_range(30, 1));
            start_us  = ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                                 : CFG_W'($urandom_range(3000));
            cruise_us = ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                                 : CFG_W'($urandom_range(start_us));
            set_ramp(span, start_us, cruise_us);
            run_random_traffic(170);
        end
    endtask

    initial
    begin : main
        ramp_span   = CFG_W'(RESET_SPAN);
        ramp_start  = CFG_W'(RESET_START);
        ramp_cruise = CFG_W'(RESET_MIN);
        ramp_slope  = slope_for(ramp_span, ramp_start, ramp_cruise);
        coil_phase  = '0;
        goal_pos    = '0;
        step_fwd    = 1'b0;
        last_stamp  = '0;
        steps_made  = '0;
        steps_owed  = '0;
        motor_en    = '0;
        coil_drive  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 17;
        rx_idle_pct = 59;
        check_reset_defaults();
        check_targets_and_motors();
        check_ramp_profile();
        check_config_extremes();

        run_idle_mix(17, 59);
        run_idle_mix(59, 17);
        run_idle_mix(0, 0);

        in_valid <= 1'b0;
        for (int w = 0; w < 2000 && coil_expect_q.size() != 0; w++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (coil_expect_q.size() != 0)
            report_mismatch("results never delivered", 32'(coil_expect_q.size()), '0);

        $display("Covered %0d move starts and %0d updates (%0d steps, %0d within tolerance),",
                 n_starts, n_updates, n_steps, n_done);
        $display("%0d ramp register writes, %0d result beats checked, %0d mismatches.",
                 n_cfg_writes, n_results, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
